// ===== rtl/core/sliding_window_anagram_finder_assert.svh =====
// Assertion helpers shared by the anagram finder RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef SLIDING_WINDOW_ANAGRAM_FINDER_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_FINDER_ASSERT_SVH

// invariant checked every cycle out of reset
`define SWAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SWAF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/swaf_pkg.sv =====
package swaf_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int LETTER_W    = 5;
  localparam int COUNT_W     = 5;
  localparam int POS_W       = 32;

  localparam logic [LETTER_W-1:0] LETTER_LIMIT = 5'd26;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_PATTERN = 2'd1;
  localparam logic [1:0] KIND_TEXT    = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_PAT    = 3'd2,
    OP_REJECT = 3'd3,
    OP_TEXT   = 3'd4
  } op_t;

  // one classified item on its way from front to back
  typedef struct packed {
    op_t                 op;
    logic [LETTER_W-1:0] letter;
    logic                full;
    logic [LETTER_W-1:0] leaving;
  } q_entry_t;

endpackage

// ===== rtl/core/swaf_if.sv =====
interface swaf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] letter;

  modport source (output valid, output kind, output letter, input ready);
  modport sink   (input valid, input kind, input letter, output ready);
endinterface

interface swaf_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] start_index;
  logic        error;

  modport source (output valid, output hit, output start_index, output error, input ready);
  modport sink   (input valid, input hit, input start_index, input error, output ready);
endinterface

// ===== rtl/core/sliding_window_anagram_finder.sv =====
// Sliding-window anagram finder.
// in_if carries kind and letter: kind 0 clears all state, 1 appends a pattern
// letter, 2 feeds a text letter; kind 3 is ignored. Every input transaction
// gives exactly one out_if transaction: hit and start_index for text letters,
// error for rejected pattern letters (overflow, late arrival or bad code),
// all zero otherwise. start_index saturates at its maximum.
// Throughput is one item per cycle while out_if.ready stays high. A result
// passes the classification and window ring read register, then the
// four-entry queue, then the output register before it appears on out_if.
// The front holds the pattern length, text position and a one-read one-write
// window ring of MAX_PATTERN entries; the back holds the 26 letter balances
// and the distinct and balanced counters and updates them for each item.
// Reset (rst_n low, synchronous) empties the pipeline and clears the pattern;
// the ring needs no clearing since only slots written since the last clear
// are used. When out_if.ready is low the result waits in the output register,
// the queue fills, and only then does in_if.ready drop.
module sliding_window_anagram_finder #(
  parameter int unsigned MAX_PATTERN = 256
) (
  input logic         clk,
  input logic         rst_n,
  swaf_in_if.sink     in_if,
  swaf_out_if.source  out_if
);

  logic               push_valid;
  logic               push_ready;
  swaf_pkg::q_entry_t push_entry;
  logic               head_valid;
  logic               head_ready;
  swaf_pkg::q_entry_t head;

  swaf_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  swaf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (head_valid),
    .pop_entry  (head),
    .pop_ready  (head_ready)
  );

  swaf_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_ready (head_ready),
    .out_if     (out_if)
  );

endmodule

// ===== rtl/core/swaf_front.sv =====
`include "sliding_window_anagram_finder_assert.svh"

module swaf_front #(
  parameter int unsigned MAX_PATTERN = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  swaf_in_if.sink             in_if,
  output logic                push_valid,
  output swaf_pkg::q_entry_t  push_entry,
  input  logic                push_ready
);

  localparam int PL_W = $clog2(MAX_PATTERN + 1);
  localparam int AW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [PL_W-1:0] MAX_LEN = PL_W'(MAX_PATTERN);
  localparam logic [AW-1:0]   WP_LAST = AW'(MAX_PATTERN - 1);

  logic                          text_started_r, text_started_nxt;
  logic [PL_W-1:0]               pat_len_r, pat_len_nxt;
  logic [swaf_pkg::POS_W-1:0]    text_pos_r, text_pos_nxt;
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  swaf_pkg::op_t                 s1_op_r, s1_op_nxt;
  logic [swaf_pkg::LETTER_W-1:0] s1_letter_r;
  logic                          s1_full_r, s1_full_nxt;
  logic [swaf_pkg::LETTER_W-1:0] ring_rd_r;
  logic [swaf_pkg::LETTER_W-1:0] ring_mem [MAX_PATTERN];

  logic            accept;
  logic            ring_we;
  logic            full;
  logic [PL_W-1:0] wp_ext;
  logic [PL_W-1:0] rd_full;
  logic [AW-1:0]   rd_addr;

  assign in_if.ready = !s1_valid_r || push_ready;
  assign accept      = in_if.valid && in_if.ready;

  // oldest window slot: written pattern-length text letters ago
  assign wp_ext  = PL_W'(wp_r);
  assign full    = text_pos_r >= swaf_pkg::POS_W'(pat_len_r);
  assign rd_full = (wp_ext >= pat_len_r) ? (wp_ext - pat_len_r)
                                         : (wp_ext + MAX_LEN - pat_len_r);
  assign rd_addr = rd_full[AW-1:0];

  always_comb begin
    text_started_nxt = text_started_r;
    pat_len_nxt      = pat_len_r;
    text_pos_nxt     = text_pos_r;
    wp_nxt           = wp_r;
    s1_op_nxt        = swaf_pkg::OP_NONE;
    s1_full_nxt      = 1'b0;
    ring_we          = 1'b0;
    s1_valid_nxt     = accept ? 1'b1 : (push_ready ? 1'b0 : s1_valid_r);
    if (accept) begin
      case (in_if.kind)
        swaf_pkg::KIND_CLEAR: begin
          s1_op_nxt        = swaf_pkg::OP_CLEAR;
          text_started_nxt = 1'b0;
          pat_len_nxt      = '0;
          text_pos_nxt     = '0;
          wp_nxt           = '0;
        end
        swaf_pkg::KIND_PATTERN: begin
          if (text_started_r || pat_len_r >= MAX_LEN ||
              in_if.letter >= swaf_pkg::LETTER_LIMIT) begin
            s1_op_nxt = swaf_pkg::OP_REJECT;
          end else begin
            s1_op_nxt   = swaf_pkg::OP_PAT;
            pat_len_nxt = pat_len_r + PL_W'(1);
          end
        end
        swaf_pkg::KIND_TEXT: begin
          text_started_nxt = 1'b1;
          if (text_pos_r != '1) begin
            text_pos_nxt = text_pos_r + swaf_pkg::POS_W'(1);
          end
          if (pat_len_r != '0) begin
            s1_op_nxt   = swaf_pkg::OP_TEXT;
            s1_full_nxt = full;
            ring_we     = 1'b1;
            wp_nxt      = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
          end
        end
        default: begin
          s1_op_nxt = swaf_pkg::OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_started_r <= 1'b0;
      pat_len_r      <= '0;
      text_pos_r     <= '0;
      wp_r           <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      text_started_r <= text_started_nxt;
      pat_len_r      <= pat_len_nxt;
      text_pos_r     <= text_pos_nxt;
      wp_r           <= wp_nxt;
      s1_valid_r     <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= s1_op_nxt;
      s1_letter_r <= in_if.letter;
      s1_full_r   <= s1_full_nxt;
    end
  end

  // window ring: read-before-write when the read and write slots coincide
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= in_if.letter;
    end
    if (accept) begin
      ring_rd_r <= ring_mem[rd_addr];
    end
  end

  assign push_valid = s1_valid_r;

  always_comb begin
    push_entry.op      = s1_op_r;
    push_entry.letter  = s1_letter_r;
    push_entry.full    = s1_full_r;
    push_entry.leaving = ring_rd_r;
  end

  `SWAF_ASSERT(a_len_max, pat_len_r <= MAX_LEN, "pattern length above maximum")
  `SWAF_ASSERT(a_wp_range, wp_r <= WP_LAST, "ring write pointer out of range")
  `SWAF_ASSERT_IMPL(a_pos_idle, !text_started_r, text_pos_r == '0, "text position moved before text")

endmodule

// ===== rtl/core/swaf_fifo.sv =====
module swaf_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  swaf_pkg::q_entry_t push_entry,
  output logic               push_ready,
  output logic               pop_valid,
  output swaf_pkg::q_entry_t pop_entry,
  input  logic               pop_ready
);

  localparam logic [swaf_pkg::QCNT_W-1:0] CNT_FULL = swaf_pkg::QCNT_W'(swaf_pkg::QUEUE_DEPTH);

  swaf_pkg::q_entry_t               mem_r [swaf_pkg::QUEUE_DEPTH];
  logic [swaf_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [swaf_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [swaf_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             push;
  logic                             pop;

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + swaf_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + swaf_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + swaf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - swaf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/swaf_back.sv =====
`include "sliding_window_anagram_finder_assert.svh"

module swaf_back #(
  parameter int unsigned MAX_PATTERN = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  swaf_pkg::q_entry_t head,
  output logic               head_ready,
  swaf_out_if.source         out_if
);

  localparam int BAL_W = $clog2(MAX_PATTERN + 1) + 1;
  localparam logic signed [BAL_W-1:0] BAL_ONE = BAL_W'(1);

  logic signed [BAL_W-1:0]       bal_r   [swaf_pkg::NUM_LETTERS];
  logic signed [BAL_W-1:0]       bal_nxt [swaf_pkg::NUM_LETTERS];
  logic signed [BAL_W-1:0]       bal_in  [swaf_pkg::NUM_LETTERS];
  logic [swaf_pkg::COUNT_W-1:0]  distinct_r, distinct_nxt;
  logic [swaf_pkg::COUNT_W-1:0]  balanced_r, balanced_nxt;
  logic [swaf_pkg::POS_W-1:0]    ws_r, ws_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r;
  logic [swaf_pkg::POS_W-1:0]    out_start_r;
  logic                          out_error_r;

  logic [swaf_pkg::NUM_LETTERS-1:0] enter;
  logic [swaf_pkg::NUM_LETTERS-1:0] leave;
  logic [swaf_pkg::NUM_LETTERS-1:0] add_pat;
  logic [swaf_pkg::NUM_LETTERS-1:0] hit_zero;
  logic [swaf_pkg::NUM_LETTERS-1:0] left_zero;
  logic [swaf_pkg::NUM_LETTERS-1:0] new_letter;
  logic                             pop;
  logic                             is_text;
  logic                             hit_now;

  assign head_ready = !out_valid_r || out_if.ready;
  assign pop        = head_valid && head_ready;
  assign is_text    = head.op == swaf_pkg::OP_TEXT;

  // per-letter lanes: the new letter enters first, then the oldest leaves
  always_comb begin
    for (int i = 0; i < swaf_pkg::NUM_LETTERS; i++) begin
      enter[i]      = is_text && head.letter == swaf_pkg::LETTER_W'(i);
      leave[i]      = is_text && head.full && head.leaving == swaf_pkg::LETTER_W'(i);
      add_pat[i]    = head.op == swaf_pkg::OP_PAT && head.letter == swaf_pkg::LETTER_W'(i);
      bal_in[i]     = enter[i] ? bal_r[i] - BAL_ONE : bal_r[i];
      hit_zero[i]   = enter[i] && bal_in[i] == '0;
      left_zero[i]  = leave[i] && bal_in[i] == '0;
      new_letter[i] = add_pat[i] && bal_r[i] == '0;
      bal_nxt[i]    = (leave[i] || add_pat[i]) ? bal_in[i] + BAL_ONE : bal_in[i];
    end
  end

  always_comb begin
    balanced_nxt = balanced_r + swaf_pkg::COUNT_W'(|hit_zero)
                 - swaf_pkg::COUNT_W'(|left_zero);
    distinct_nxt = distinct_r + swaf_pkg::COUNT_W'(|new_letter);
    ws_nxt       = ws_r;
    if (is_text && head.full && ws_r != '1) begin
      ws_nxt = ws_r + swaf_pkg::POS_W'(1);
    end
    hit_now       = balanced_nxt == distinct_r;
    out_valid_nxt = pop ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < swaf_pkg::NUM_LETTERS; i++) begin
        bal_r[i] <= '0;
      end
      distinct_r  <= '0;
      balanced_r  <= '0;
      ws_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (head.op == swaf_pkg::OP_CLEAR) begin
          for (int i = 0; i < swaf_pkg::NUM_LETTERS; i++) begin
            bal_r[i] <= '0;
          end
          distinct_r <= '0;
          balanced_r <= '0;
          ws_r       <= '0;
        end else begin
          for (int i = 0; i < swaf_pkg::NUM_LETTERS; i++) begin
            bal_r[i] <= bal_nxt[i];
          end
          distinct_r <= distinct_nxt;
          balanced_r <= balanced_nxt;
          ws_r       <= ws_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_hit_r   <= is_text && hit_now;
      out_start_r <= is_text ? ws_nxt : '0;
      out_error_r <= head.op == swaf_pkg::OP_REJECT;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.hit         = out_hit_r;
  assign out_if.start_index = out_start_r;
  assign out_if.error       = out_error_r;

  `SWAF_ASSERT(a_bal_le_dist, balanced_r <= distinct_r, "balanced count above distinct count")
  `SWAF_ASSERT(a_dist_range, distinct_r <= swaf_pkg::COUNT_W'(swaf_pkg::NUM_LETTERS), "distinct count out of range")
  `SWAF_ASSERT_NEXT(a_clear, pop && head.op == swaf_pkg::OP_CLEAR, distinct_r == '0 && balanced_r == '0 && ws_r == '0, "clear left state behind")

endmodule
